FILE: rtl/ptmap_pkg.sv
`default_nettype none
package ptmap_pkg;

  localparam int unsigned NUM_TABLES_DEF = 64;
  localparam int unsigned ENTRY_W        = 64;
  localparam int unsigned IDX_W          = 9;
  localparam int unsigned VPN_W          = 36;
  localparam int unsigned FRAME_W        = 40;
  localparam int unsigned FLAGS_W        = 12;
  localparam int unsigned USED_W         = 7;
  localparam int unsigned STATUS_W       = 2;
  localparam int unsigned IN_DATA_W      = 88;
  localparam int unsigned OUT_DATA_W     = 72;

  localparam logic [FRAME_W-1:0] BASE_RESET  = 40'd256;
  localparam logic [FLAGS_W-1:0] TABLE_FLAGS = 12'h007;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_MISSING   = 2'd1,
    ST_EXHAUSTED = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_EVAL,
    S_LINK,
    S_LEAF,
    S_DONE
  } state_t;

  typedef struct packed {
    logic    load_req;
    logic    rd_en;
    logic    follow;
    logic    link_wr;
    logic    leaf_wr;
    logic    clr_wr;
    logic    set_st;
    status_t st;
    logic    out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic entry_zero;
    logic entry_bad;
    logic pool_full;
    logic alloc;
    logic last_upper;
    logic clr_done;
    logic out_busy;
  } dp_stat_t;

endpackage
`default_nettype wire

FILE: rtl/ptmap_ram.sv
`default_nettype none
module ptmap_ram #(
  parameter int unsigned W     = 64,
  parameter int unsigned DEPTH = 32768,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [W-1:0]  wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

FILE: rtl/ptmap_ctrl.sv
`default_nettype none
module ptmap_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire ptmap_pkg::dp_stat_t   stat,
  output ptmap_pkg::ctrl_cmd_t       cmd
);
  import ptmap_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: if (stat.clr_done) state_nxt = S_IDLE;
      S_IDLE:  if (in_tvalid) state_nxt = S_READ;
      S_READ:  state_nxt = S_EVAL;
      S_EVAL: begin
        if (stat.entry_zero) begin
          if (!stat.alloc || stat.pool_full) state_nxt = S_DONE;
          else state_nxt = S_LINK;
        end else if (stat.entry_bad) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = stat.last_upper ? S_LEAF : S_READ;
        end
      end
      S_LINK:  state_nxt = stat.last_upper ? S_LEAF : S_READ;
      S_LEAF:  state_nxt = S_DONE;
      S_DONE:  if (!stat.out_busy) state_nxt = S_IDLE;
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_comb begin
    cmd       = '0;
    cmd.st    = ST_OK;
    in_tready = 1'b0;
    case (state_r)
      S_CLEAR: cmd.clr_wr = 1'b1;
      S_IDLE: begin
        in_tready    = 1'b1;
        cmd.load_req = in_tvalid;
      end
      S_READ: cmd.rd_en = 1'b1;
      S_EVAL: begin
        if (stat.entry_zero) begin
          if (!stat.alloc) begin
            cmd.set_st = 1'b1;
            cmd.st     = ST_MISSING;
          end else if (stat.pool_full) begin
            cmd.set_st = 1'b1;
            cmd.st     = ST_EXHAUSTED;
          end
        end else if (stat.entry_bad) begin
          cmd.set_st = 1'b1;
          cmd.st     = ST_MISSING;
        end else begin
          cmd.follow = 1'b1;
        end
      end
      S_LINK: cmd.link_wr = 1'b1;
      S_LEAF: begin
        cmd.leaf_wr = 1'b1;
        cmd.set_st  = 1'b1;
        cmd.st      = ST_OK;
      end
      S_DONE: cmd.out_load = !stat.out_busy;
      default: cmd = '0;
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/ptmap_dp.sv
`default_nettype none
module ptmap_dp #(
  parameter int unsigned NUM_TABLES = ptmap_pkg::NUM_TABLES_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_wr_en,
  input  wire logic [ptmap_pkg::FRAME_W-1:0]       cfg_wr_data,
  input  wire logic                                in_opcode,
  input  wire logic [ptmap_pkg::VPN_W-1:0]         in_virt_page,
  input  wire logic [ptmap_pkg::FRAME_W-1:0]       in_phys_frame,
  input  wire logic [ptmap_pkg::FLAGS_W-1:0]       in_flags,
  input  wire ptmap_pkg::ctrl_cmd_t                cmd,
  output ptmap_pkg::dp_stat_t                      stat,
  input  wire logic                                out_tready,
  output logic                                     out_valid,
  output logic [ptmap_pkg::STATUS_W-1:0]           out_status,
  output logic [ptmap_pkg::ENTRY_W-1:0]            out_leaf_value,
  output logic [ptmap_pkg::USED_W-1:0]             out_tables_used
);
  import ptmap_pkg::*;

  localparam int unsigned PW    = $clog2(NUM_TABLES);
  localparam int unsigned NW    = PW + 1;
  localparam int unsigned DEPTH = NUM_TABLES * 512;
  localparam int unsigned AW    = $clog2(DEPTH);
  // address field of an entry, bits 58:12
  localparam int unsigned EF_W  = 47;

  // request and walk registers
  logic                 alloc_r;
  logic [VPN_W-1:0]     vpn_r;
  logic [FRAME_W-1:0]   phys_r;
  logic [FLAGS_W-1:0]   flags_r;
  logic [1:0]           lvl_r, lvl_nxt;
  logic [PW-1:0]        page_r, page_nxt;
  logic [NW-1:0]        nf_r, nf_nxt;
  logic [FRAME_W-1:0]   base_r, base_nxt;
  logic [AW-1:0]        clr_r, clr_nxt;
  status_t              st_r;

  logic                 ov_r, ov_nxt;
  logic [STATUS_W-1:0]  ost_r;
  logic [ENTRY_W-1:0]   oleaf_r;
  logic [USED_W-1:0]    oused_r;

  logic [IDX_W-1:0]     idx;
  logic [ENTRY_W-1:0]   rdata;
  logic [EF_W:0]        diff;
  logic [FRAME_W:0]     new_frame;
  logic [ENTRY_W-1:0]   link_entry;
  logic [ENTRY_W-1:0]   leaf_entry;
  logic                 we;
  logic [AW-1:0]        waddr;
  logic [ENTRY_W-1:0]   wdata;
  logic [AW-1:0]        raddr;

  always_comb begin
    case (lvl_r)
      2'd0:    idx = vpn_r[35:27];
      2'd1:    idx = vpn_r[26:18];
      2'd2:    idx = vpn_r[17:9];
      default: idx = vpn_r[8:0];
    endcase
  end

  // entry frame relative to pool base; a borrow means below the pool
  assign diff       = {1'b0, rdata[58:12]} - (EF_W+1)'(base_r);
  assign new_frame  = {1'b0, base_r} + (FRAME_W+1)'(nf_r);
  assign link_entry = {11'd0, new_frame, TABLE_FLAGS};
  assign leaf_entry = {12'd0, phys_r, flags_r};

  assign raddr = AW'({page_r, idx});

  always_comb begin
    we    = cmd.clr_wr | cmd.link_wr | cmd.leaf_wr;
    waddr = AW'({page_r, idx});
    wdata = leaf_entry;
    if (cmd.clr_wr) begin
      waddr = clr_r;
      wdata = '0;
    end else if (cmd.link_wr) begin
      wdata = link_entry;
    end
  end

  ptmap_ram #(
    .W     (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (cmd.rd_en),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    stat.entry_zero = (rdata == '0);
    stat.entry_bad  = diff[EF_W] | (diff[EF_W-1:0] >= EF_W'(nf_r));
    stat.pool_full  = (nf_r >= NW'(NUM_TABLES));
    stat.alloc      = alloc_r;
    stat.last_upper = (lvl_r == 2'd2);
    stat.clr_done   = (clr_r == AW'(DEPTH - 1));
    stat.out_busy   = ov_r & ~out_tready;
  end

  always_comb begin
    lvl_nxt  = lvl_r;
    page_nxt = page_r;
    nf_nxt   = nf_r;
    base_nxt = cfg_wr_en ? cfg_wr_data : base_r;
    clr_nxt  = cmd.clr_wr ? clr_r + AW'(1) : clr_r;
    ov_nxt   = cmd.out_load ? 1'b1 : (out_tready ? 1'b0 : ov_r);
    if (cmd.load_req) begin
      lvl_nxt  = 2'd0;
      page_nxt = '0;
    end else if (cmd.follow) begin
      lvl_nxt  = lvl_r + 2'd1;
      page_nxt = diff[PW-1:0];
    end else if (cmd.link_wr) begin
      lvl_nxt  = lvl_r + 2'd1;
      page_nxt = nf_r[PW-1:0];
      nf_nxt   = nf_r + NW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lvl_r  <= '0;
      page_r <= '0;
      nf_r   <= NW'(1);
      base_r <= BASE_RESET;
      clr_r  <= '0;
      ov_r   <= 1'b0;
      st_r   <= ST_OK;
    end else begin
      lvl_r  <= lvl_nxt;
      page_r <= page_nxt;
      nf_r   <= nf_nxt;
      base_r <= base_nxt;
      clr_r  <= clr_nxt;
      ov_r   <= ov_nxt;
      if (cmd.set_st) st_r <= cmd.st;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      alloc_r <= in_opcode;
      vpn_r   <= in_virt_page;
      phys_r  <= in_phys_frame;
      flags_r <= in_flags;
    end
    if (cmd.out_load) begin
      ost_r   <= st_r;
      oleaf_r <= (st_r == ST_OK) ? leaf_entry : '0;
      oused_r <= USED_W'(nf_r);
    end
  end

  assign out_valid       = ov_r;
  assign out_status      = ost_r;
  assign out_leaf_value  = oleaf_r;
  assign out_tables_used = oused_r;

endmodule
`default_nettype wire

FILE: rtl/four_level_page_table_mapper_top.sv
`default_nettype none
// Channel | Ports         | tdata (low bit up)                  | tuser
// --------+---------------+-------------------------------------+--------
// request | in_t*         | virt_page 36, phys_frame 40, flags 12| opcode
// result  | out_t*        | leaf_value 64, tables_used 7, pad 1 | status
// config  | cfg_wr_en/data| pool_base_frame 40                  | -
//
// One request at a time through a single table RAM: accept, then a read and an
// evaluate step per walked level, a link write per newly allocated table, the leaf
// write and the result load; errors finish sooner.
// After reset a clearing pass writes zero to all NUM_TABLES*512 entries (one a
// cycle) before the first request is taken. A stalled result holds in the output
// register; the next request is accepted meanwhile and waits only at its end.
module four_level_page_table_mapper_top #(
  parameter int unsigned NUM_TABLES = ptmap_pkg::NUM_TABLES_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_wr_en,
  input  wire logic [ptmap_pkg::FRAME_W-1:0]      cfg_wr_data,   // pool_base_frame
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  input  wire logic [ptmap_pkg::IN_DATA_W-1:0]    in_tdata,      // virt_page, phys_frame, flags
  input  wire logic                               in_tuser,      // opcode
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  output logic [ptmap_pkg::OUT_DATA_W-1:0]        out_tdata,     // leaf_value, tables_used
  output logic [ptmap_pkg::STATUS_W-1:0]          out_tuser      // status
);
  import ptmap_pkg::*;

  ctrl_cmd_t             cmd;
  dp_stat_t              stat;
  logic [ENTRY_W-1:0]    leaf_value;
  logic [USED_W-1:0]     tables_used;

  ptmap_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ptmap_dp #(
    .NUM_TABLES (NUM_TABLES)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_opcode       (in_tuser),
    .in_virt_page    (in_tdata[35:0]),
    .in_phys_frame   (in_tdata[75:36]),
    .in_flags        (in_tdata[87:76]),
    .cmd             (cmd),
    .stat            (stat),
    .out_tready      (out_tready),
    .out_valid       (out_tvalid),
    .out_status      (out_tuser),
    .out_leaf_value  (leaf_value),
    .out_tables_used (tables_used)
  );

  assign out_tdata = {1'b0, tables_used, leaf_value};

  // one RAM operation per cycle
  a_one_ram_op: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.rd_en, cmd.link_wr, cmd.leaf_wr, cmd.clr_wr}))
    else $error("more than one table RAM operation in a cycle");

  a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("request accepted while another is walking");

  a_err_no_leaf: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser != ST_OK) |-> (out_tdata[63:0] == '0))
    else $error("failed request reports a leaf value");

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !(out_tvalid && !out_tready))
    else $error("result overwritten while stalled");

endmodule
`default_nettype wire

FILE: tb/sv/testbench.sv
module testbench;
  import ptmap_pkg::*;

  localparam int unsigned TABLES      = NUM_TABLES_DEF;
  localparam int unsigned PAGE_SLOTS  = 512;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam logic [63:0] ADDR_STRIP  = 64'hf800_0000_0000_0fff;
  localparam logic [FRAME_W-1:0] BASE_MAX = '1;

  typedef struct {
    status_t           status;
    logic [63:0]       leaf;
    logic [USED_W-1:0] used;
  } map_result_t;

  // Mirrors the table store and the pool allocator; one expected result per request.
  class map_scoreboard;
    logic [63:0]  table_store [TABLES*PAGE_SLOTS];
    int unsigned  pages_used;
    logic [63:0]  pool_base;
    map_result_t  expected_q[$];
    int           errors;

    function new();
      foreach (table_store[i]) table_store[i] = '0;
      pages_used = 1;
      pool_base  = 64'(BASE_RESET);
      errors     = 0;
    endfunction

    function void set_base(logic [FRAME_W-1:0] b);
      pool_base = 64'(b);
    endfunction

    function void note_request(logic alloc, logic [VPN_W-1:0] vpn,
                               logic [FRAME_W-1:0] frame, logic [FLAGS_W-1:0] flg);
      logic [IDX_W-1:0] idx [4];
      int unsigned      page;
      int unsigned      slot;
      logic [63:0]      e;
      logic [63:0]      off;
      map_result_t      r;
      idx[0] = vpn[35:27];
      idx[1] = vpn[26:18];
      idx[2] = vpn[17:9];
      idx[3] = vpn[8:0];
      page = 0;
      r.status = ST_OK;
      r.leaf = '0;
      for (int lvl = 0; lvl < 3; lvl++) begin
        slot = page * PAGE_SLOTS + idx[lvl];
        e = table_store[slot];
        if (e == 0) begin
          if (!alloc) begin
            r.status = ST_MISSING;
            break;
          end
          if (pages_used >= TABLES) begin
            r.status = ST_EXHAUSTED;
            break;
          end
          table_store[slot] = ((pool_base + 64'(pages_used)) << 12) | 64'(TABLE_FLAGS);
          page = pages_used;
          pages_used++;
        end else begin
          // decoded against the current base; wraps to huge when below it
          off = ((e & ~ADDR_STRIP) >> 12) - pool_base;
          if (off >= 64'(pages_used)) begin
            r.status = ST_MISSING;
            break;
          end
          page = int'(off);
        end
      end
      if (r.status == ST_OK) begin
        r.leaf = (64'(frame) << 12) | 64'(flg);
        table_store[page * PAGE_SLOTS + idx[3]] = r.leaf;
      end
      r.used = USED_W'(pages_used);
      expected_q.push_back(r);
    endfunction

    task report(string what);
      $display("mismatch: %s", what);
      errors++;
    endtask

    task check_result(logic [STATUS_W-1:0] st, logic [63:0] leaf, logic [USED_W-1:0] used);
      map_result_t x;
      if (expected_q.size() == 0) begin
        report($sformatf("result with nothing pending: status %0d leaf %h", st, leaf));
        return;
      end
      x = expected_q.pop_front();
      if (st !== x.status)
        report($sformatf("status %0d, want %0d", st, x.status));
      if (leaf !== x.leaf)
        report($sformatf("leaf_value %h, want %h", leaf, x.leaf));
      if (used !== x.used)
        report($sformatf("tables_used %0d, want %0d", used, x.used));
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_wr_en;
  logic [FRAME_W-1:0]    cfg_wr_data;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [STATUS_W-1:0]   out_tuser;

  map_scoreboard sb;
  logic [26:0]   prefixes[$];
  bit            idle_on = 1'b1;
  int unsigned   stall_left = 0;
  int unsigned   cycles = 0;

  four_level_page_table_mapper_top u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // result side back-pressure in random bursts while idle_on is set
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      out_tready <= 1'b0;
      stall_left <= $urandom_range(0, 6);
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_result(out_tuser, out_tdata[63:0], out_tdata[64 +: USED_W]);
  end

  task automatic send_request(input logic op, input logic [VPN_W-1:0] vpn,
                              input logic [FRAME_W-1:0] frame,
                              input logic [FLAGS_W-1:0] flg);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {flg, frame, vpn};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_request(op, vpn, frame, flg);
    @(negedge clk);
  endtask

  task automatic send_tracked(input logic op, input logic [VPN_W-1:0] vpn,
                              input logic [FRAME_W-1:0] frame,
                              input logic [FLAGS_W-1:0] flg);
    prefixes.push_back(vpn[35:9]);
    send_request(op, vpn, frame, flg);
  endtask

  // Mostly reuses walked prefixes so requests reach the leaf; some change one
  // level, a few are fully random addresses.
  task automatic random_request(input int fresh_pct);
    int               r;
    int unsigned      lvl;
    logic [26:0]      p;
    logic [VPN_W-1:0] vpn;
    r = $urandom_range(0, 99);
    if (prefixes.size() == 0 || r < fresh_pct) begin
      vpn = VPN_W'({$urandom, $urandom});
    end else begin
      p = prefixes[$urandom_range(0, prefixes.size() - 1)];
      if (r < fresh_pct + 10) begin
        lvl = $urandom_range(0, 2);
        p[lvl*9 +: 9] = 9'($urandom);
      end
      vpn = {p, 9'($urandom)};
    end
    if (r < fresh_pct + 10) begin
      if (prefixes.size() < 48)
        prefixes.push_back(vpn[35:9]);
      else
        prefixes[$urandom_range(0, 47)] = vpn[35:9];
    end
    send_request(1'($urandom_range(0, 1)), vpn, FRAME_W'({$urandom, $urandom}),
                 FLAGS_W'($urandom));
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_base(input logic [FRAME_W-1:0] b);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= b;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    sb.set_base(b);
  endtask

  initial begin
    logic [FRAME_W-1:0] bases [6];
    int                 counts [6];
    int                 fresh;
    sb = new();
    rst_n       = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = 1'b0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // directed: missing root, zero leaf, all-ones fields, each allocation depth
    send_tracked(1'b0, 36'h0, 40'h12345, 12'h001);
    send_tracked(1'b1, 36'h0, 40'h0, 12'h000);
    send_tracked(1'b1, 36'hf_ffff_ffff, BASE_MAX, 12'hfff);
    send_tracked(1'b0, 36'hf_ffff_ffff, 40'h1, 12'h000);
    send_tracked(1'b0, 36'h1, 40'hff_0000_00ff, 12'h800);
    send_tracked(1'b0, 36'h200, 40'h3, 12'h003);
    send_tracked(1'b1, 36'h200, 40'h4, 12'h004);
    send_tracked(1'b1, 36'h4_0000, 40'h5, 12'h005);
    send_tracked(1'b1, 36'h800_0000, 40'h6, 12'h006);
    send_tracked(1'b0, 36'h800_01ff, 40'haa_aaaa_aaaa, 12'h555);
    send_tracked(1'b1, 36'h800_0000, 40'h55_5555_5555, 12'haaa);
    send_tracked(1'b0, 36'h7_ffff_fe00, 40'h7, 12'h0f0);

    bases[0] = BASE_RESET;           counts[0] = 380;
    bases[1] = BASE_RESET - 1;       counts[1] = 150;
    bases[2] = '0;                   counts[2] = 100;
    bases[3] = BASE_MAX;             counts[3] = 100;
    bases[4] = FRAME_W'({$urandom, $urandom}); counts[4] = 120;
    bases[5] = BASE_RESET;           counts[5] = 650;

    for (int ph = 0; ph < 6; ph++) begin
      if (ph > 0) begin
        wait_drained();
        write_base(bases[ph]);
      end
      fresh = (ph == 5) ? 12 : 4;
      for (int i = 0; i < counts[ph]; i++) begin
        idle_on = !(ph == 5 && i >= counts[ph] - 300);
        random_request(fresh);
      end
    end
    in_tvalid <= 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
